/* rtl/core/mssl_pkg.sv */
`timescale 1ns / 1ps
// mssl_pkg: shared types, register codes and fixed-point constants of the
// multichannel setpoint slew limiter. no dependencies.
package mssl_pkg;

  localparam int DEF_DRIVE_CHANNELS = 6;
  localparam int DEF_STEER_CHANNELS = 4;
  localparam int CMD_DEPTH          = 2;
  localparam int OUT_DEPTH          = 8;

  localparam int RATE_W  = 15;
  localparam int VAL_W   = 15;
  localparam int MAG_W   = 14;
  localparam int DGAIN_W = 16;
  localparam int SGAIN_W = 20;
  localparam int PROD_W  = MAG_W + SGAIN_W;
  localparam int X_W     = 26;
  localparam int CMD_W   = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_RATE_UP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_RATE_DOWN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_RATE_UP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_RATE_DOWN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_GAIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_DIR_MASK  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_DIR_MASK  = 3'd7;

  localparam logic signed [15:0] FULL_SCALE     = 16'sd10000;
  localparam logic signed [15:0] NEG_FULL_SCALE = -16'sd10000;

  // whole-percent truncation: floor(mag/100) = (mag*5243) >> 19 for mag <= 10000
  localparam logic [12:0] TRUNC_RECIP = 13'd5243;
  localparam int          TRUNC_SHIFT = 19;

  // drive: round(p / 2^15); steer: round(p / 25600) = ((p + 12800) >> 8) / 100
  localparam logic [34:0] DRIVE_ROUND   = 35'd16384;
  localparam int          DRIVE_SHIFT   = 15;
  localparam logic [34:0] STEER_ROUND   = 35'd12800;
  localparam int          STEER_SHIFT   = 8;
  localparam logic [X_W-1:0] STEER_X_LIMIT = 26'd40960000;
  localparam logic [X_W-1:0] RECIP_100     = 26'd42949673;
  localparam int             RECIP_SHIFT   = 32;

  typedef struct packed {
    logic              opcode;
    logic [3:0]        channel;
    logic signed [15:0] target_value;
  } mssl_in_t;

  typedef struct packed {
    logic [3:0]               out_channel;
    logic signed [CMD_W-1:0]  command_value;
    logic                     last;
  } mssl_out_t;

  typedef struct packed {
    logic                     tick;
    logic [3:0]               channel;
    logic signed [VAL_W-1:0]  target;
  } mssl_cmd_t;

  typedef struct packed {
    logic [RATE_W-1:0]  drive_rate_up;
    logic [RATE_W-1:0]  drive_rate_down;
    logic [RATE_W-1:0]  steer_rate_up;
    logic [RATE_W-1:0]  steer_rate_down;
    logic [DGAIN_W-1:0] drive_gain;
    logic [SGAIN_W-1:0] steer_gain;
    logic [5:0]         drive_dir_mask;
    logic [3:0]         steer_dir_mask;
  } mssl_cfg_t;

  localparam mssl_cfg_t CFG_RESET = '{
    drive_rate_up:   15'd5000,
    drive_rate_down: 15'd5000,
    steer_rate_up:   15'd10000,
    steer_rate_down: 15'd10000,
    drive_gain:      16'd9830,
    steer_gain:      20'd58253,
    drive_dir_mask:  6'd58,
    steer_dir_mask:  4'd10
  };

  typedef enum logic {
    BK_IDLE,
    BK_TICK
  } mssl_back_state_t;

endpackage

/* rtl/core/mssl_fifo.sv */
`timescale 1ns / 1ps
// mssl_fifo: small register queue with occupancy count.
// standalone, used for the command queue and the result queue.
module mssl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             pop_data,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/core/mssl_front.sv */
`timescale 1ns / 1ps
// mssl_front: input side; decodes items, clamps set targets, truncates steering
// set targets, drops sets to absent channels. depends on mssl_pkg.
module mssl_front #(
  parameter int DRIVE_CHANNELS = 6,
  parameter int STEER_CHANNELS = 4
) (
  input  logic               push,
  input  mssl_pkg::mssl_in_t item,
  output logic               full,
  input  logic               cmd_full,
  output logic               cmd_push,
  output mssl_pkg::mssl_cmd_t cmd
);
  import mssl_pkg::*;

  localparam int NUM_CH = DRIVE_CHANNELS + STEER_CHANNELS;

  logic                    is_tick;
  logic                    in_range;
  logic                    is_steer;
  logic signed [VAL_W-1:0] tc;
  logic signed [VAL_W-1:0] neg_tc;
  logic                    tneg;
  logic [MAG_W-1:0]        mag;
  logic [26:0]             trunc_prod;
  logic [6:0]              pct;
  logic [MAG_W-1:0]        trunc_mag;
  logic signed [VAL_W-1:0] trunc_s;
  logic signed [VAL_W-1:0] tv;

  always_comb begin
    is_tick  = item.opcode == OP_TICK;
    in_range = 6'(item.channel) < 6'(NUM_CH);
    is_steer = 6'(item.channel) >= 6'(DRIVE_CHANNELS);

    if (item.target_value > FULL_SCALE) begin
      tc = VAL_W'(FULL_SCALE);
    end else if (item.target_value < NEG_FULL_SCALE) begin
      tc = VAL_W'(NEG_FULL_SCALE);
    end else begin
      tc = VAL_W'(item.target_value);
    end

    // truncate toward zero to a whole percent
    tneg       = tc < 0;
    neg_tc     = -tc;
    mag        = tneg ? MAG_W'(neg_tc) : MAG_W'(tc);
    trunc_prod = 27'(mag) * 27'(TRUNC_RECIP);
    pct        = 7'(trunc_prod >> TRUNC_SHIFT);
    trunc_mag  = MAG_W'({pct, 6'b0}) + MAG_W'({pct, 5'b0}) + MAG_W'({pct, 2'b0});
    trunc_s    = $signed(VAL_W'(trunc_mag));
    tv         = is_steer ? (tneg ? -trunc_s : trunc_s) : tc;

    cmd.tick    = is_tick;
    cmd.channel = item.channel;
    cmd.target  = tv;
  end

  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full && (is_tick || in_range);

endmodule

/* rtl/core/mssl_back.sv */
`timescale 1ns / 1ps
// mssl_back: executes queued commands; target store, per-channel ramp and
// the scaling pipeline feeding the result queue. depends on mssl_pkg.
module mssl_back #(
  parameter int DRIVE_CHANNELS = 6,
  parameter int STEER_CHANNELS = 4
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  mssl_pkg::mssl_cfg_t                       cfg,
  input  logic                                      cmd_empty,
  input  mssl_pkg::mssl_cmd_t                       cmd,
  output logic                                      cmd_pop,
  input  logic [$clog2(mssl_pkg::OUT_DEPTH+1)-1:0]  res_count,
  output logic                                      res_push,
  output mssl_pkg::mssl_out_t                       res
);
  import mssl_pkg::*;

  localparam int NUM_CH = DRIVE_CHANNELS + STEER_CHANNELS;
  localparam int CH_W   = $clog2(NUM_CH);
  localparam int CNT_W  = $clog2(OUT_DEPTH + 1) + 1;

  logic signed [VAL_W-1:0] target_store [NUM_CH];
  logic signed [VAL_W-1:0] ramped_value [NUM_CH];

  mssl_back_state_t state, state_next;
  logic [CH_W-1:0]  idx, idx_next;
  logic             ts_we;
  logic             issue;
  logic             credit;
  logic [CNT_W-1:0] inflight;

  // ramp
  logic signed [VAL_W-1:0] cur;
  logic signed [VAL_W-1:0] tgt;
  logic                    is_drive;
  logic                    grow;
  logic [RATE_W-1:0]       rate;
  logic signed [15:0]      diff;
  logic [15:0]             absdiff;
  logic [15:0]             step;
  logic signed [16:0]      new17;
  logic signed [VAL_W-1:0] new_val;
  logic signed [VAL_W-1:0] neg_new;
  logic [MAG_W-1:0]        new_mag;
  logic [5:0]              idx6;
  logic [5:0]              sidx6;
  logic [15:0]             dmask16;
  logic [15:0]             smask16;
  logic                    dir_bit;

  // pipeline
  logic              v1, v2, v3;
  logic [MAG_W-1:0]  s1_mag;
  logic              s1_flip, s2_flip, s3_flip;
  logic              s1_drive, s2_drive, s3_drive;
  logic [3:0]        s1_ch, s2_ch, s3_ch;
  logic              s1_last, s2_last, s3_last;
  logic [PROD_W-1:0] s2_prod;
  logic [X_W-1:0]    s3_x;
  logic [34:0]       drive_sum;
  logic [34:0]       steer_sum;
  logic [34:0]       steer_y;
  logic [X_W-1:0]    x_next;
  logic [2*X_W-1:0]  q_prod;
  logic [CMD_W-1:0]  q_mag;
  logic signed [CMD_W-1:0] q_s;

  always_comb begin
    cur      = ramped_value[idx];
    tgt      = target_store[idx];
    idx6     = 6'(idx);
    sidx6    = idx6 - 6'(DRIVE_CHANNELS);
    is_drive = idx6 < 6'(DRIVE_CHANNELS);
    dmask16  = 16'(cfg.drive_dir_mask);
    smask16  = 16'(cfg.steer_dir_mask);
    dir_bit  = is_drive ? dmask16[idx6[3:0]] : smask16[sidx6[3:0]];

    grow = (cur >= 0 && tgt > 0 && cur < tgt) || (cur <= 0 && tgt < 0 && cur > tgt);
    if (is_drive) begin
      rate = grow ? cfg.drive_rate_up : cfg.drive_rate_down;
    end else begin
      rate = grow ? cfg.steer_rate_up : cfg.steer_rate_down;
    end
    diff    = 16'(tgt) - 16'(cur);
    absdiff = (diff < 0) ? 16'(-diff) : 16'(diff);
    step    = (16'(rate) < absdiff) ? 16'(rate) : absdiff;
    new17   = (tgt > cur) ? (17'(cur) + $signed({1'b0, step}))
                          : (17'(cur) - $signed({1'b0, step}));
    new_val = new17[VAL_W-1:0];
    neg_new = -new_val;
    new_mag = (new_val < 0) ? MAG_W'(neg_new) : MAG_W'(new_val);
  end

  assign inflight = CNT_W'(v1) + CNT_W'(v2) + CNT_W'(v3);
  assign credit   = (CNT_W'(res_count) + inflight) < CNT_W'(OUT_DEPTH);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd_pop    = 1'b0;
    ts_we      = 1'b0;
    issue      = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.tick) begin
            state_next = BK_TICK;
            idx_next   = '0;
          end else begin
            ts_we = 1'b1;
          end
        end
      end
      BK_TICK: begin
        if (credit) begin
          issue = 1'b1;
          if (idx == CH_W'(NUM_CH - 1)) begin
            state_next = BK_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        target_store[i] <= '0;
        ramped_value[i] <= '0;
      end
    end else begin
      if (ts_we) begin
        target_store[CH_W'(cmd.channel)] <= cmd.target;
      end
      if (issue) begin
        ramped_value[idx] <= new_val;
      end
    end
  end

  // stage 2 rounding prescale, stage 3 reciprocal divide for steering
  always_comb begin
    drive_sum = 35'(s2_prod) + DRIVE_ROUND;
    steer_sum = 35'(s2_prod) + STEER_ROUND;
    steer_y   = steer_sum >> STEER_SHIFT;
    if (s2_drive) begin
      x_next = X_W'(drive_sum >> DRIVE_SHIFT);
    end else if (steer_y > 35'(STEER_X_LIMIT)) begin
      x_next = STEER_X_LIMIT;
    end else begin
      x_next = X_W'(steer_y);
    end

    q_prod = (2*X_W)'(s3_x) * (2*X_W)'(RECIP_100);
    q_mag  = s3_drive ? CMD_W'(s3_x) : CMD_W'(q_prod >> RECIP_SHIFT);
    q_s    = $signed(q_mag);

    res.out_channel   = s3_ch;
    res.command_value = s3_flip ? -q_s : q_s;
    res.last          = s3_last;
  end

  assign res_push = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    s1_mag   <= new_mag;
    s1_flip  <= (new_val < 0) ^ dir_bit;
    s1_drive <= is_drive;
    s1_ch    <= 4'(idx);
    s1_last  <= idx == CH_W'(NUM_CH - 1);

    s2_prod  <= PROD_W'(s1_mag) * PROD_W'(s1_drive ? SGAIN_W'(cfg.drive_gain) : cfg.steer_gain);
    s2_flip  <= s1_flip;
    s2_drive <= s1_drive;
    s2_ch    <= s1_ch;
    s2_last  <= s1_last;

    s3_x     <= x_next;
    s3_flip  <= s2_flip;
    s3_drive <= s2_drive;
    s3_ch    <= s2_ch;
    s3_last  <= s2_last;
  end

endmodule

/* rtl/core/multichannel_setpoint_slew_limiter.sv */
`timescale 1ns / 1ps
// multichannel_setpoint_slew_limiter: top level; configuration registers,
// command queue, front and back ends, result queue. depends on mssl_pkg,
// mssl_fifo, mssl_front, mssl_back.
// A set item is taken into a two-entry command queue and written to the target
// store by the back end while it is idle. A tick walks all DRIVE_CHANNELS +
// STEER_CHANNELS channels through one shared ramp and scaling pipeline, one
// channel per cycle while the result queue has room; the pipeline stalls
// whenever the eight-entry result queue, counting the beats still in the
// pipeline, has no room left. There is no clearing pass after reset.
// Configuration writes are always ready and must only be issued while
// the block is idle.
module multichannel_setpoint_slew_limiter #(
  parameter int DRIVE_CHANNELS = mssl_pkg::DEF_DRIVE_CHANNELS,
  parameter int STEER_CHANNELS = mssl_pkg::DEF_STEER_CHANNELS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  mssl_pkg::mssl_in_t                    item,
  output logic                                  empty,
  input  logic                                  pop,
  output mssl_pkg::mssl_out_t                   result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mssl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mssl_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import mssl_pkg::*;

  localparam int NUM_CH = DRIVE_CHANNELS + STEER_CHANNELS;
  localparam int OCW    = $clog2(OUT_DEPTH + 1);

  mssl_cfg_t cfg;
  mssl_cmd_t cmd;
  mssl_cmd_t cmd_head;
  logic      cmd_push;
  logic      cmd_pop;
  logic      cmd_full;
  logic      cmd_empty;
  mssl_out_t res;
  logic      res_push;
  logic      res_full;
  logic [OCW-1:0] res_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DRIVE_RATE_UP:   cfg.drive_rate_up   <= cfg_data[RATE_W-1:0];
        CFG_DRIVE_RATE_DOWN: cfg.drive_rate_down <= cfg_data[RATE_W-1:0];
        CFG_STEER_RATE_UP:   cfg.steer_rate_up   <= cfg_data[RATE_W-1:0];
        CFG_STEER_RATE_DOWN: cfg.steer_rate_down <= cfg_data[RATE_W-1:0];
        CFG_DRIVE_GAIN:      cfg.drive_gain      <= cfg_data[DGAIN_W-1:0];
        CFG_STEER_GAIN:      cfg.steer_gain      <= cfg_data[SGAIN_W-1:0];
        CFG_DRIVE_DIR_MASK:  cfg.drive_dir_mask  <= cfg_data[5:0];
        CFG_STEER_DIR_MASK:  cfg.steer_dir_mask  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  mssl_front #(
    .DRIVE_CHANNELS(DRIVE_CHANNELS),
    .STEER_CHANNELS(STEER_CHANNELS)
  ) u_front (
    .push     (push),
    .item     (item),
    .full     (full),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  mssl_fifo #(
    .WIDTH($bits(mssl_cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd),
    .pop       (cmd_pop),
    .pop_data  (cmd_head),
    .full      (cmd_full),
    .empty     (cmd_empty),
    .count     ()
  );

  mssl_back #(
    .DRIVE_CHANNELS(DRIVE_CHANNELS),
    .STEER_CHANNELS(STEER_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res       (res)
  );

  mssl_fifo #(
    .WIDTH($bits(mssl_out_t)),
    .DEPTH(OUT_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .pop       (pop),
    .pop_data  (result),
    .full      (res_full),
    .empty     (empty),
    .count     (res_count)
  );

`ifndef SYNTH
  // pipeline credit must keep the result queue from overflowing
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result beat pushed into a full queue");

  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.last) |-> result.out_channel == 4'(NUM_CH - 1))
    else $error("last flag on a channel other than the final one");

  a_set_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd_push && !cmd.tick) |-> 6'(cmd.channel) < 6'(NUM_CH))
    else $error("set command queued for an absent channel");
`endif

endmodule
